/* src/quaternion_to_euler_macros.svh */
// Assertion macros for the quaternion to Euler angle converter.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef QUATERNION_TO_EULER_MACROS_SVH
`define QUATERNION_TO_EULER_MACROS_SVH
`ifndef SYNTHESIS
`define QTE_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);
`define QTE_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);
`else
`define QTE_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg)
`define QTE_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg)
`endif
`endif

/* src/qte_pkg.sv */
// Shared constants, types and the arctangent table of the quaternion converter.
// No dependencies.
`default_nettype none

package qte_pkg;

    localparam int CORDIC_STEPS  = 16;
    localparam int TAB_LEN       = 24;
    localparam int IN_W          = 16;
    localparam int PROD_W        = 32;
    localparam int ARG_W         = 35;
    localparam int CW            = 46;
    localparam int PRE_TOP       = 40;
    localparam int SHIFT_STAGES  = 6;
    localparam int ACC_W         = 32;
    localparam int ANG_W         = 16;
    localparam int D_W           = 33;
    localparam int S_W           = 32;
    localparam int SQ_IN_W       = 64;
    localparam int SQ_ROOT_W     = SQ_IN_W / 2;
    localparam int SQ_REM_W      = SQ_ROOT_W + 2;
    localparam int C_W           = SQ_ROOT_W + 1;
    localparam int ATAN_LAT      = 1 + SHIFT_STAGES + CORDIC_STEPS;

    localparam logic [ACC_W-1:0] ACC_PI     = 32'h8000_0000;
    localparam logic [ACC_W-1:0] ACC_ROUND  = 32'h0000_8000;
    localparam logic signed [ANG_W-1:0] HALF_PI_ANGLE = 16'sd16384;

    typedef struct packed {
        logic zero;
        logic clamp;
        logic a_pos;
    } flags_t;

    typedef struct packed {
        flags_t                  flags;
        logic                    big;
        logic signed [ARG_W-1:0] roll_y;
        logic signed [ARG_W-1:0] roll_x;
        logic signed [ARG_W-1:0] yaw_y;
        logic signed [ARG_W-1:0] yaw_x;
        logic signed [ARG_W-1:0] pitch_y;
    } side_t;

    // atan(2^-i), 2^31 = pi
    function automatic logic [ACC_W-1:0] atan_entry(input int i);
        logic [ACC_W-1:0] v;
        case (i)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* src/quaternion_to_euler.sv */
// Top level: quaternion (Q1.15) to ZYX Euler binary angles, fully pipelined.
// Depends on qte_pkg, qte_isqrt, qte_atan2 and quaternion_to_euler_macros.svh.
//
//   channel | signals                                           | dir
//   input   | in_valid, in_ready, quat_w/x/y/z                  | in
//   output  | out_valid, out_ready, roll/pitch/yaw_angle,       | out
//           | pitch_clamped, zero_quaternion                    |
//
// One transaction per cycle while the output is not held. The pipeline is made of
// the product and sum stages, 32 square root stages, 7 + CORDIC_STEPS
// atan2 stages and the output register. The square root chain sets the depth.
// rst_n clears only valid bits. When the output holds an untaken result the
// whole pipeline freezes; in_ready is low exactly then.
`default_nettype none
`include "quaternion_to_euler_macros.svh"

module quaternion_to_euler (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic signed [qte_pkg::IN_W-1:0]      quat_w,
    input  wire logic signed [qte_pkg::IN_W-1:0]      quat_x,
    input  wire logic signed [qte_pkg::IN_W-1:0]      quat_y,
    input  wire logic signed [qte_pkg::IN_W-1:0]      quat_z,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed [qte_pkg::ANG_W-1:0]          roll_angle,
    output logic signed [qte_pkg::ANG_W-1:0]          pitch_angle,
    output logic signed [qte_pkg::ANG_W-1:0]          yaw_angle,
    output logic                                      pitch_clamped,
    output logic                                      zero_quaternion
);

    localparam int PW = qte_pkg::PROD_W;
    localparam int AW = qte_pkg::ARG_W;

    logic en;
    logic out_valid_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // stage 1: products
    logic signed [PW-1:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [PW-1:0] wx_reg, yz_reg, wz_reg, xy_reg, wy_reg, zx_reg;
    logic                 s1_valid_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ww_reg <= PW'(quat_w) * PW'(quat_w);
            xx_reg <= PW'(quat_x) * PW'(quat_x);
            yy_reg <= PW'(quat_y) * PW'(quat_y);
            zz_reg <= PW'(quat_z) * PW'(quat_z);
            wx_reg <= PW'(quat_w) * PW'(quat_x);
            yz_reg <= PW'(quat_y) * PW'(quat_z);
            wz_reg <= PW'(quat_w) * PW'(quat_z);
            xy_reg <= PW'(quat_x) * PW'(quat_y);
            wy_reg <= PW'(quat_w) * PW'(quat_y);
            zx_reg <= PW'(quat_z) * PW'(quat_x);
        end
    end

    // stage 2: scale-free terms
    logic signed [AW-1:0] n2_next, a_next, ry_next, rx_next, yy2_next, yx_next;
    logic signed [AW-1:0] n2_reg, a_reg, ry_reg, rx_reg, yy2_reg, yx_reg;
    logic                 s2_valid_reg;

    always_comb
    begin
        n2_next  = AW'(ww_reg) + AW'(xx_reg) + AW'(yy_reg) + AW'(zz_reg);
        a_next   = (AW'(wy_reg) - AW'(zx_reg)) <<< 1;
        ry_next  = (AW'(wx_reg) + AW'(yz_reg)) <<< 1;
        rx_next  = n2_next - ((AW'(xx_reg) + AW'(yy_reg)) <<< 1);
        yy2_next = (AW'(wz_reg) + AW'(xy_reg)) <<< 1;
        yx_next  = n2_next - ((AW'(yy_reg) + AW'(zz_reg)) <<< 1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n2_reg  <= n2_next;
            a_reg   <= a_next;
            ry_reg  <= ry_next;
            rx_reg  <= rx_next;
            yy2_reg <= yy2_next;
            yx_reg  <= yx_next;
        end
    end

    // stage 3: clamp test and multiplier operands
    logic signed [AW-1:0]        aa, d_full, s_full;
    logic                        big;
    logic [qte_pkg::D_W-1:0]     d_reg;
    logic [qte_pkg::S_W-1:0]     s_next, s_reg;
    qte_pkg::side_t              side3_next, side3_reg;
    logic                        s3_valid_reg;

    always_comb
    begin
        aa     = a_reg[AW-1] ? -a_reg : a_reg;
        d_full = n2_reg - aa;
        s_full = n2_reg + aa;
        big    = (s_full >>> 31) != '0;
        s_next = big ? s_full[qte_pkg::S_W+1:2] : s_full[qte_pkg::S_W-1:0];
        side3_next.flags.zero  = (n2_reg == '0);
        side3_next.flags.clamp = (aa >= n2_reg);
        side3_next.flags.a_pos = !a_reg[AW-1];
        side3_next.big         = big;
        side3_next.roll_y      = ry_reg;
        side3_next.roll_x      = rx_reg;
        side3_next.yaw_y       = yy2_reg;
        side3_next.yaw_x       = yx_reg;
        side3_next.pitch_y     = a_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg     <= d_full[qte_pkg::D_W-1:0];
            s_reg     <= s_next;
            side3_reg <= side3_next;
        end
    end

    // stage 4: radicand product
    logic [qte_pkg::D_W+qte_pkg::S_W-1:0] prod;
    logic [qte_pkg::SQ_IN_W-1:0]          rad_reg;
    qte_pkg::side_t                       side4_reg;
    logic                                 s4_valid_reg;

    assign prod = (qte_pkg::D_W + qte_pkg::S_W)'(d_reg) * (qte_pkg::D_W + qte_pkg::S_W)'(s_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg   <= prod[qte_pkg::SQ_IN_W-1:0];
            side4_reg <= side3_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    logic                              sq_valid;
    logic [qte_pkg::SQ_ROOT_W-1:0]     sq_root;
    qte_pkg::side_t                    sq_side;

    qte_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s4_valid_reg),
        .radicand  (rad_reg),
        .in_side   (side4_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_side  (sq_side)
    );

    logic [qte_pkg::C_W-1:0]  cos_mag;
    logic signed [AW-1:0]     pitch_x;

    assign cos_mag = sq_side.big ? {sq_root, 1'b0} : {1'b0, sq_root};
    assign pitch_x = $signed(AW'(cos_mag));

    logic                              roll_v, pitch_v, yaw_v, atan_valid;
    logic signed [qte_pkg::ANG_W-1:0]  roll_raw, pitch_raw, yaw_raw;

    qte_atan2 u_roll (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .arg_y     (sq_side.roll_y),
        .arg_x     (sq_side.roll_x),
        .out_valid (roll_v),
        .angle     (roll_raw)
    );

    qte_atan2 u_pitch (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .arg_y     (sq_side.pitch_y),
        .arg_x     (pitch_x),
        .out_valid (pitch_v),
        .angle     (pitch_raw)
    );

    qte_atan2 u_yaw (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .arg_y     (sq_side.yaw_y),
        .arg_x     (sq_side.yaw_x),
        .out_valid (yaw_v),
        .angle     (yaw_raw)
    );

    assign atan_valid = roll_v && pitch_v && yaw_v;

    // flags ride alongside the atan2 pipes
    qte_pkg::flags_t flag_s [0:qte_pkg::ATAN_LAT];

    assign flag_s[0] = sq_side.flags;

    for (genvar k = 0; k < qte_pkg::ATAN_LAT; k++)
    begin : g_flag
        qte_pkg::flags_t f_reg;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                f_reg <= flag_s[k];
            end
        end

        assign flag_s[k+1] = f_reg;
    end

    qte_pkg::flags_t                   fl;
    logic signed [qte_pkg::ANG_W-1:0]  roll_next, pitch_next, yaw_next;
    logic signed [qte_pkg::ANG_W-1:0]  roll_reg, pitch_reg, yaw_reg;
    logic                              clamp_next, clamp_reg, zero_reg;

    always_comb
    begin
        fl         = flag_s[qte_pkg::ATAN_LAT];
        roll_next  = roll_raw;
        yaw_next   = yaw_raw;
        clamp_next = 1'b0;
        if (pitch_raw > qte_pkg::HALF_PI_ANGLE)
        begin
            pitch_next = qte_pkg::HALF_PI_ANGLE;
        end
        else if (pitch_raw < -qte_pkg::HALF_PI_ANGLE)
        begin
            pitch_next = -qte_pkg::HALF_PI_ANGLE;
        end
        else
        begin
            pitch_next = pitch_raw;
        end
        if (fl.zero)
        begin
            roll_next  = '0;
            pitch_next = '0;
            yaw_next   = '0;
        end
        else if (fl.clamp)
        begin
            clamp_next = 1'b1;
            pitch_next = fl.a_pos ? qte_pkg::HALF_PI_ANGLE : -qte_pkg::HALF_PI_ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= atan_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            roll_reg  <= roll_next;
            pitch_reg <= pitch_next;
            yaw_reg   <= yaw_next;
            clamp_reg <= clamp_next;
            zero_reg  <= fl.zero;
        end
    end

    assign out_valid       = out_valid_reg;
    assign roll_angle      = roll_reg;
    assign pitch_angle     = pitch_reg;
    assign yaw_angle       = yaw_reg;
    assign pitch_clamped   = clamp_reg;
    assign zero_quaternion = zero_reg;

    `QTE_ASSERT_IMP(a_zero_out, clk, rst_n, out_valid && zero_quaternion, roll_angle == '0 && pitch_angle == '0 && yaw_angle == '0 && !pitch_clamped, "zero quaternion with nonzero result")
    `QTE_ASSERT_IMP(a_pitch_rng, clk, rst_n, out_valid, pitch_angle <= qte_pkg::HALF_PI_ANGLE && pitch_angle >= -qte_pkg::HALF_PI_ANGLE, "pitch out of range")
    `QTE_ASSERT_IMP(a_clamp_val, clk, rst_n, out_valid && pitch_clamped, pitch_angle == qte_pkg::HALF_PI_ANGLE || pitch_angle == -qte_pkg::HALF_PI_ANGLE, "clamp without half pi pitch")
    `QTE_ASSERT_NXT(a_stall_frz, clk, rst_n, !en, $stable(s1_valid_reg) && $stable(sq_valid) && $stable(atan_valid), "pipeline moved during stall")

endmodule

`default_nettype wire

/* src/qte_isqrt.sv */
// Pipelined integer square root, one result bit per stage, side data carried along.
// Depends on qte_pkg.
`default_nettype none

module qte_isqrt (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [qte_pkg::SQ_IN_W-1:0]   radicand,
    input  wire qte_pkg::side_t                in_side,
    output logic                               out_valid,
    output logic [qte_pkg::SQ_ROOT_W-1:0]      root,
    output qte_pkg::side_t                     out_side
);

    localparam int N = qte_pkg::SQ_ROOT_W;

    logic [qte_pkg::SQ_IN_W-1:0]   rad_s   [0:N];
    logic [qte_pkg::SQ_REM_W-1:0]  rem_s   [0:N];
    logic [qte_pkg::SQ_ROOT_W-1:0] root_s  [0:N];
    qte_pkg::side_t                side_s  [0:N];
    logic                          valid_s [0:N];

    assign rad_s[0]   = radicand;
    assign rem_s[0]   = '0;
    assign root_s[0]  = '0;
    assign side_s[0]  = in_side;
    assign valid_s[0] = in_valid;

    for (genvar j = 0; j < N; j++)
    begin : g_stage
        localparam int DIG = N - 1 - j;

        logic [qte_pkg::SQ_REM_W-1:0]  rem_sh;
        logic [qte_pkg::SQ_REM_W-1:0]  trial;
        logic [qte_pkg::SQ_REM_W-1:0]  rem_next;
        logic [qte_pkg::SQ_ROOT_W-1:0] root_next;
        logic [qte_pkg::SQ_REM_W-1:0]  rem_reg;
        logic [qte_pkg::SQ_ROOT_W-1:0] root_reg;
        logic [qte_pkg::SQ_IN_W-1:0]   rad_reg;
        qte_pkg::side_t                side_reg;
        logic                          valid_reg;

        always_comb
        begin
            rem_sh = {rem_s[j][qte_pkg::SQ_REM_W-3:0], rad_s[j][2*DIG+1 -: 2]};
            trial  = {root_s[j], 2'b01};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_s[j][qte_pkg::SQ_ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_s[j][qte_pkg::SQ_ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg <= 1'b0;
            end
            else if (en)
            begin
                valid_reg <= valid_s[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg  <= rem_next;
                root_reg <= root_next;
                rad_reg  <= rad_s[j];
                side_reg <= side_s[j];
            end
        end

        assign rad_s[j+1]   = rad_reg;
        assign rem_s[j+1]   = rem_reg;
        assign root_s[j+1]  = root_reg;
        assign side_s[j+1]  = side_reg;
        assign valid_s[j+1] = valid_reg;
    end

    assign out_valid = valid_s[N];
    assign root      = root_s[N];
    assign out_side  = side_s[N];

endmodule

`default_nettype wire

/* src/qte_atan2.sv */
// Pipelined atan2: sign fold, normalizing prescale, then a vectoring CORDIC.
// Depends on qte_pkg.
`default_nettype none

module qte_atan2 (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              en,
    input  wire logic                              in_valid,
    input  wire logic signed [qte_pkg::ARG_W-1:0]  arg_y,
    input  wire logic signed [qte_pkg::ARG_W-1:0]  arg_x,
    output logic                                   out_valid,
    output logic signed [qte_pkg::ANG_W-1:0]       angle
);

    localparam int CW = qte_pkg::CW;
    localparam int SH = qte_pkg::SHIFT_STAGES;
    localparam int NS = qte_pkg::CORDIC_STEPS;

    logic signed [CW-1:0]            px   [0:SH];
    logic signed [CW-1:0]            py   [0:SH];
    logic [CW-1:0]                   pm   [0:SH];
    logic [qte_pkg::ACC_W-1:0]       pacc [0:SH];
    logic                            pz   [0:SH];
    logic                            pv   [0:SH];

    logic signed [CW-1:0]            cx   [0:NS];
    logic signed [CW-1:0]            cy   [0:NS];
    logic [qte_pkg::ACC_W-1:0]       cacc [0:NS];
    logic                            cz   [0:NS];
    logic                            cv   [0:NS];

    // fold into the right half plane
    logic signed [CW-1:0]      ex, ey, fx_next, fy_next;
    logic [CW-1:0]             m_next;
    logic [qte_pkg::ACC_W-1:0] acc0_next;
    logic                      zero_next;
    logic signed [CW-1:0]      fx_reg, fy_reg;
    logic [CW-1:0]             m_reg;
    logic [qte_pkg::ACC_W-1:0] acc0_reg;
    logic                      zero_reg;
    logic                      v0_reg;

    always_comb
    begin
        ex        = CW'(arg_x);
        ey        = CW'(arg_y);
        zero_next = (arg_x == '0) && (arg_y == '0);
        if (ex < 0)
        begin
            fx_next   = -ex;
            fy_next   = -ey;
            acc0_next = qte_pkg::ACC_PI;
        end
        else
        begin
            fx_next   = ex;
            fy_next   = ey;
            acc0_next = '0;
        end
        m_next = fx_next | (fy_next < 0 ? -fy_next : fy_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fx_reg   <= fx_next;
            fy_reg   <= fy_next;
            m_reg    <= m_next;
            acc0_reg <= acc0_next;
            zero_reg <= zero_next;
        end
    end

    assign px[0]   = fx_reg;
    assign py[0]   = fy_reg;
    assign pm[0]   = m_reg;
    assign pacc[0] = acc0_reg;
    assign pz[0]   = zero_reg;
    assign pv[0]   = v0_reg;

    // binary search of the shift that lifts the larger magnitude to 2^40
    for (genvar s = 0; s < SH; s++)
    begin : g_pre
        localparam int K = 1 << (SH - 1 - s);

        logic                      lift;
        logic signed [CW-1:0]      x_next, y_next, x_reg, y_reg;
        logic [CW-1:0]             m_next_s, m_reg_s;
        logic [qte_pkg::ACC_W-1:0] acc_reg;
        logic                      zero_reg_s;
        logic                      valid_reg;

        always_comb
        begin
            lift     = (pm[s] >> (qte_pkg::PRE_TOP + 1 - K)) == '0;
            x_next   = lift ? (px[s] <<< K) : px[s];
            y_next   = lift ? (py[s] <<< K) : py[s];
            m_next_s = lift ? (pm[s] << K) : pm[s];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg <= 1'b0;
            end
            else if (en)
            begin
                valid_reg <= pv[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg      <= x_next;
                y_reg      <= y_next;
                m_reg_s    <= m_next_s;
                acc_reg    <= pacc[s];
                zero_reg_s <= pz[s];
            end
        end

        assign px[s+1]   = x_reg;
        assign py[s+1]   = y_reg;
        assign pm[s+1]   = m_reg_s;
        assign pacc[s+1] = acc_reg;
        assign pz[s+1]   = zero_reg_s;
        assign pv[s+1]   = valid_reg;
    end

    assign cx[0]   = px[SH];
    assign cy[0]   = py[SH];
    assign cacc[0] = pacc[SH];
    assign cz[0]   = pz[SH];
    assign cv[0]   = pv[SH];

    for (genvar i = 0; i < NS; i++)
    begin : g_iter
        logic signed [CW-1:0]      dx, dy, x_next, y_next, x_reg, y_reg;
        logic [qte_pkg::ACC_W-1:0] acc_next, acc_reg;
        logic                      zero_reg_i;
        logic                      valid_reg;

        always_comb
        begin
            dx = cy[i] >>> i;
            dy = cx[i] >>> i;
            if (!cy[i][CW-1])
            begin
                x_next   = cx[i] + dx;
                y_next   = cy[i] - dy;
                acc_next = cacc[i] + qte_pkg::atan_entry(i);
            end
            else
            begin
                x_next   = cx[i] - dx;
                y_next   = cy[i] + dy;
                acc_next = cacc[i] - qte_pkg::atan_entry(i);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg <= 1'b0;
            end
            else if (en)
            begin
                valid_reg <= cv[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg      <= x_next;
                y_reg      <= y_next;
                acc_reg    <= acc_next;
                zero_reg_i <= cz[i];
            end
        end

        assign cx[i+1]   = x_reg;
        assign cy[i+1]   = y_reg;
        assign cacc[i+1] = acc_reg;
        assign cz[i+1]   = zero_reg_i;
        assign cv[i+1]   = valid_reg;
    end

    logic [qte_pkg::ACC_W-1:0] acc_rnd;

    assign acc_rnd   = cacc[NS] + qte_pkg::ACC_ROUND;
    assign angle     = cz[NS] ? '0 : $signed(acc_rnd[qte_pkg::ACC_W-1 -: qte_pkg::ANG_W]);
    assign out_valid = cv[NS];

endmodule

`default_nettype wire
